// ===== sv/dsm_pkg.sv =====
// Shared types and constants for the automaton string matcher.
package dsm_pkg;

   localparam int MAX_PATTERN_DEF   = 16;
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int BYTE_W            = 8;
   localparam int POS_W             = 32;
   localparam int SHIFT_W           = 33;

   localparam logic [BYTE_W-1:0] FIRST_LETTER = 8'h61;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_BUILD  = 2'd2,
      ACT_TEXT   = 2'd3
   } dsm_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEXT,
      ST_FETCH,
      ST_LATCH,
      ST_READ,
      ST_WRITE,
      ST_FREAD,
      ST_FCMP
   } dsm_state_type;

   typedef struct packed {
      logic load;
      logic clear_pos;
   } dsm_res_cmd_type;

endpackage

// ===== sv/dsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/dsm_ctrl.sv =====
// Sequencer: pattern loading, table build over the shared table port, text stepping.
module dsm_ctrl
   import dsm_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  res_free,
   output dsm_res_cmd_type       res_cmd,
   output logic [$clog2(MAX_PATTERN+1)-1:0] res_state,
   output logic [$clog2(MAX_PATTERN+1)-1:0] res_length,
   output logic                  pat_we,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_waddr,
   output logic [BYTE_W-1:0]     pat_wdata,
   output logic                  pat_re,
   output logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] pat_raddr,
   input  logic [BYTE_W-1:0]     pat_rdata,
   output logic                  tbl_we,
   output logic [$clog2((MAX_PATTERN+1)*ALPHABET_SIZE)-1:0] tbl_waddr,
   output logic [$clog2(MAX_PATTERN+1)-1:0] tbl_wdata,
   output logic                  tbl_re,
   output logic [$clog2((MAX_PATTERN+1)*ALPHABET_SIZE)-1:0] tbl_raddr,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] tbl_rdata,
   output logic                  fail_we,
   output logic [$clog2(MAX_PATTERN+1)-1:0] fail_waddr,
   output logic [$clog2(MAX_PATTERN+1)-1:0] fail_wdata,
   output logic                  fail_re,
   output logic [$clog2(MAX_PATTERN+1)-1:0] fail_raddr,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] fail_rdata
);

   localparam int Rows    = MAX_PATTERN + 1;
   localparam int StateW  = $clog2(Rows);
   localparam int PatAw   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int TblAw   = $clog2(Rows * ALPHABET_SIZE);
   localparam int LetterW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

   localparam logic [StateW-1:0]  MaxLen     = StateW'(MAX_PATTERN);
   localparam logic [LetterW-1:0] LastLetter = LetterW'(ALPHABET_SIZE - 1);

   function automatic logic [TblAw-1:0] tbl_addr(input logic [StateW-1:0] s,
                                                 input logic [LetterW-1:0] l);
      tbl_addr = TblAw'(s) * TblAw'(ALPHABET_SIZE) + TblAw'(l);
   endfunction

   dsm_state_type      st_ff, st_in;
   logic [StateW-1:0]  len_ff, len_in;
   logic [StateW-1:0]  cur_ff, cur_in;
   logic [StateW-1:0]  q_ff, q_in;
   logic [StateW-1:0]  x_ff, x_in;
   logic [StateW-1:0]  k_ff, k_in;
   logic [LetterW-1:0] j_ff, j_in;
   logic [BYTE_W-1:0]  pbyte_ff, pbyte_in;
   logic               hit_ff, hit_in;
   logic [Rows-1:0]    row_valid_ff, row_valid_in;

   dsm_action_type     act;
   logic               acc;
   logic [BYTE_W-1:0]  text_idx;
   logic               letter_ok;
   logic [LetterW-1:0] text_letter;
   logic [BYTE_W-1:0]  letter_byte;
   logic               extend;
   logic [StateW-1:0]  cell_value;
   logic               row_last;
   logic               fail_hit;
   logic [StateW-1:0]  next_text_state;

   assign act         = dsm_action_type'(req_action);
   assign acc         = req_valid && req_ready;
   assign text_idx    = req_byte_value - FIRST_LETTER;
   assign letter_ok   = {1'b0, text_idx} < 9'(ALPHABET_SIZE);
   assign text_letter = letter_ok ? LetterW'(text_idx) : '0;

   // build step: extend on the pattern byte, otherwise copy from the border state's row
   assign letter_byte = FIRST_LETTER + BYTE_W'(j_ff);
   assign extend      = (q_ff < len_ff) && (pbyte_ff == letter_byte);
   assign cell_value  = extend ? (q_ff + 1'b1) : ((q_ff == '0) ? '0 : tbl_rdata);
   assign row_last    = (j_ff == LastLetter);
   assign fail_hit    = (pat_rdata == pbyte_ff);

   assign next_text_state = hit_ff ? tbl_rdata : '0;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               if (act == ACT_BUILD) begin
                  st_in = ST_FETCH;
               end else if (act == ACT_TEXT) begin
                  st_in = ST_TEXT;
               end
            end
         end
         ST_TEXT: begin
            if (res_free) begin
               st_in = ST_IDLE;
            end
         end
         ST_FETCH: st_in = ST_LATCH;
         ST_LATCH: st_in = ST_READ;
         ST_READ:  st_in = ST_WRITE;
         ST_WRITE: begin
            if (!row_last) begin
               st_in = ST_READ;
            end else if (q_ff == len_ff) begin
               st_in = ST_IDLE;
            end else if (q_ff == '0) begin
               st_in = ST_FETCH;
            end else begin
               st_in = ST_FREAD;
            end
         end
         ST_FREAD: st_in = ST_FCMP;
         ST_FCMP: begin
            if (fail_hit || k_ff == '0) begin
               st_in = ST_FETCH;
            end else begin
               st_in = ST_FREAD;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_ready  = (st_ff == ST_IDLE);
      res_cmd    = '0;
      res_state  = next_text_state;
      res_length = len_ff;
      pat_we     = 1'b0;
      pat_waddr  = len_ff[PatAw-1:0];
      pat_wdata  = req_byte_value;
      pat_re     = 1'b0;
      pat_raddr  = k_ff[PatAw-1:0];
      tbl_we     = 1'b0;
      tbl_waddr  = tbl_addr(q_ff, j_ff);
      tbl_wdata  = cell_value;
      tbl_re     = 1'b0;
      tbl_raddr  = tbl_addr(x_ff, j_ff);
      fail_we    = 1'b0;
      fail_waddr = q_ff + 1'b1;
      fail_wdata = fail_hit ? (k_ff + 1'b1) : '0;
      fail_re    = 1'b0;
      fail_raddr = k_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (act)
                  ACT_APPEND: pat_we = (len_ff < MaxLen);
                  ACT_BUILD:  res_cmd.clear_pos = 1'b1;
                  ACT_TEXT: begin
                     tbl_re    = 1'b1;
                     tbl_raddr = tbl_addr(cur_ff, text_letter);
                  end
                  ACT_CLEAR: ;
                  default: ;
               endcase
            end
         end
         ST_TEXT: res_cmd.load = res_free;
         ST_FETCH: begin
            pat_re    = 1'b1;
            pat_raddr = (q_ff < MaxLen) ? q_ff[PatAw-1:0] : '0;
         end
         ST_READ: tbl_re = 1'b1;
         ST_WRITE: begin
            tbl_we = 1'b1;
            if (row_last && q_ff == '0 && q_ff != len_ff) begin
               fail_we    = 1'b1;
               fail_wdata = '0;
            end
         end
         ST_FREAD: begin
            pat_re  = 1'b1;
            fail_re = 1'b1;
         end
         ST_FCMP: fail_we = fail_hit || (k_ff == '0);
         ST_LATCH: ;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      len_in       = len_ff;
      cur_in       = cur_ff;
      q_in         = q_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      pbyte_in     = pbyte_ff;
      hit_in       = hit_ff;
      row_valid_in = row_valid_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               unique case (act)
                  ACT_CLEAR: len_in = '0;
                  ACT_APPEND: begin
                     if (len_ff < MaxLen) begin
                        len_in = len_ff + 1'b1;
                     end
                  end
                  ACT_BUILD: begin
                     row_valid_in = '0;
                     cur_in       = '0;
                     q_in         = '0;
                     x_in         = '0;
                  end
                  ACT_TEXT: hit_in = letter_ok && row_valid_ff[cur_ff];
                  default: ;
               endcase
            end
         end
         ST_TEXT: begin
            if (res_free) begin
               cur_in = next_text_state;
            end
         end
         ST_LATCH: begin
            pbyte_in = pat_rdata;
            j_in     = '0;
         end
         ST_WRITE: begin
            if (!row_last) begin
               j_in = j_ff + 1'b1;
            end else begin
               row_valid_in[q_ff] = 1'b1;
               if (q_ff != len_ff) begin
                  if (q_ff == '0) begin
                     q_in = q_ff + 1'b1;
                     x_in = '0;
                  end else begin
                     k_in = x_ff;
                  end
               end
            end
         end
         ST_FCMP: begin
            // border chain walk for the next row's copy source
            if (fail_hit) begin
               x_in = k_ff + 1'b1;
               q_in = q_ff + 1'b1;
            end else if (k_ff == '0) begin
               x_in = '0;
               q_in = q_ff + 1'b1;
            end else begin
               k_in = fail_rdata;
            end
         end
         ST_FETCH, ST_READ, ST_FREAD: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         row_valid_ff <= '0;
      end else begin
         st_ff        <= st_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      pbyte_ff <= pbyte_in;
      hit_ff   <= hit_in;
   end

endmodule

// ===== sv/dsm_result.sv =====
// Text position counter, shift arithmetic and the result output register.
module dsm_result
   import dsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dsm_res_cmd_type       cmd,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] next_state,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] pattern_length,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_match_found,
   output logic signed [SHIFT_W-1:0] rsp_match_shift,
   output logic [$clog2(MAX_PATTERN+1)-1:0] rsp_automaton_state
);

   localparam int StateW = $clog2(MAX_PATTERN + 1);
   localparam int DiffW  = POS_W + 2;

   localparam logic [POS_W-1:0]          PosMax   = '1;
   localparam logic signed [DiffW-1:0]   DiffMax  = DiffW'(PosMax);
   localparam logic signed [DiffW-1:0]   DiffLow  = -DiffW'(1);

   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      valid_ff, valid_in;
   logic                      found_ff, found_in;
   logic signed [SHIFT_W-1:0] shift_ff, shift_in;
   logic [StateW-1:0]         state_ff;

   logic                      found;
   logic signed [DiffW-1:0]   diff;

   assign found = (next_state == pattern_length);
   assign diff  = DiffW'(pos_ff) + DiffW'(1) - DiffW'(pattern_length);
   assign free  = !valid_ff || rsp_ready;

   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      found_in = found_ff;
      shift_in = shift_ff;
      if (cmd.clear_pos) begin
         pos_in = '0;
      end
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.load) begin
         valid_in = 1'b1;
         found_in = found;
         if (pos_ff != PosMax) begin
            pos_in = pos_ff + 1'b1;
         end
         // clamp to the -1 .. max position window
         priority if (!found) begin
            shift_in = '0;
         end else if (diff > DiffMax) begin
            shift_in = SHIFT_W'(DiffMax);
         end else if (diff < DiffLow) begin
            shift_in = '1;
         end else begin
            shift_in = diff[SHIFT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      shift_ff <= shift_in;
      if (cmd.load) begin
         state_ff <= next_state;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_match_found     = found_ff;
   assign rsp_match_shift     = shift_ff;
   assign rsp_automaton_state = state_ff;

endmodule

// ===== sv/dfa_string_matcher.sv =====
// Top level of the finite automaton string matcher.
// Input beats (req_valid/req_ready) carry req_action and req_byte_value:
//   clear pattern, append pattern byte, build transition table, text byte.
// Only text bytes give a result beat on rsp_valid/rsp_ready: match flag,
// signed match shift (position - length + 1, clamped) and the new state.
// Clear and append complete without leaving idle. A text byte makes one table
// RAM read from the current state, then the result is loaded into the
// output register once it is free. A build sweeps the table one entry at
// a time, a read then a write of the table RAM, rows 0..length, with a
// fetch and latch of the pattern byte per row and a border walk between
// rows, each step a read of the border and pattern RAMs and a compare.
// req_ready is low while a build or a text lookup is in progress.
// A pending result does not block input; the next text byte waits only
// until the output register is free. While the receiver stalls, rsp_*
// hold their values.
// Reset empties the pattern, zeroes the state and text position and marks
// every table row invalid; invalid rows read as state 0, so no clearing
// pass is needed. A build also invalidates the rows before refilling.
module dfa_string_matcher
   import dsm_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [BYTE_W-1:0]         req_byte_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_match_found,
   output logic signed [SHIFT_W-1:0] rsp_match_shift,
   output logic [$clog2(MAX_PATTERN+1)-1:0] rsp_automaton_state
);

   localparam int Rows    = MAX_PATTERN + 1;
   localparam int StateW  = $clog2(Rows);
   localparam int PatAw   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int TblAw   = $clog2(Rows * ALPHABET_SIZE);

   dsm_res_cmd_type    res_cmd;
   logic               res_free;
   logic [StateW-1:0]  res_state;
   logic [StateW-1:0]  res_length;

   logic               pat_we, pat_re;
   logic [PatAw-1:0]   pat_waddr, pat_raddr;
   logic [BYTE_W-1:0]  pat_wdata, pat_rdata;

   logic               tbl_we, tbl_re;
   logic [TblAw-1:0]   tbl_waddr, tbl_raddr;
   logic [StateW-1:0]  tbl_wdata, tbl_rdata;

   logic               fail_we, fail_re;
   logic [StateW-1:0]  fail_waddr, fail_raddr;
   logic [StateW-1:0]  fail_wdata, fail_rdata;

   dsm_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (pat_waddr),
      .wdata (pat_wdata),
      .re    (pat_re),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   dsm_ram #(
      .WIDTH (StateW),
      .DEPTH (Rows * ALPHABET_SIZE)
   ) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .re    (tbl_re),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // border (failure) lengths of each pattern prefix
   dsm_ram #(
      .WIDTH (StateW),
      .DEPTH (Rows)
   ) u_border_ram (
      .clock (clock),
      .we    (fail_we),
      .waddr (fail_waddr),
      .wdata (fail_wdata),
      .re    (fail_re),
      .raddr (fail_raddr),
      .rdata (fail_rdata)
   );

   dsm_ctrl #(
      .MAX_PATTERN   (MAX_PATTERN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_byte_value (req_byte_value),
      .res_free       (res_free),
      .res_cmd        (res_cmd),
      .res_state      (res_state),
      .res_length     (res_length),
      .pat_we         (pat_we),
      .pat_waddr      (pat_waddr),
      .pat_wdata      (pat_wdata),
      .pat_re         (pat_re),
      .pat_raddr      (pat_raddr),
      .pat_rdata      (pat_rdata),
      .tbl_we         (tbl_we),
      .tbl_waddr      (tbl_waddr),
      .tbl_wdata      (tbl_wdata),
      .tbl_re         (tbl_re),
      .tbl_raddr      (tbl_raddr),
      .tbl_rdata      (tbl_rdata),
      .fail_we        (fail_we),
      .fail_waddr     (fail_waddr),
      .fail_wdata     (fail_wdata),
      .fail_re        (fail_re),
      .fail_raddr     (fail_raddr),
      .fail_rdata     (fail_rdata)
   );

   dsm_result #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_result (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (res_cmd),
      .next_state          (res_state),
      .pattern_length      (res_length),
      .free                (res_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_match_found     (rsp_match_found),
      .rsp_match_shift     (rsp_match_shift),
      .rsp_automaton_state (rsp_automaton_state)
   );

endmodule
